// File: hdl/psu_pkg.sv
// Shared constants, codes and types of the PNG scanline unfilter.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int DEF_MAX_ROW_PIXELS = 4096;
  localparam int DEF_MAX_BYTES_PER_PIXEL = 4;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] REG_ROW_PIXELS = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd2;

  localparam logic [2:0] RST_BYTES_PER_PIXEL = 3'd3;
  localparam logic [12:0] RST_ROW_PIXELS = 13'd4096;
  localparam logic [15:0] RST_IMAGE_ROWS = 16'd1;

  localparam logic [2:0] FILT_NONE = 3'd0;
  localparam logic [2:0] FILT_SUB = 3'd1;
  localparam logic [2:0] FILT_UP = 3'd2;
  localparam logic [2:0] FILT_AVG = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef struct packed {
    logic       is_data;
    logic [2:0] filter;
    logic       have_left;
    logic       have_above;
    logic       in_range;
    logic       row_end;
    logic       image_end;
  } psu_item_t;

endpackage

// File: hdl/psu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/psu_ctrl.sv
// Row and column sequencing, filter type capture and neighbor availability.
`timescale 1ns / 1ps
module psu_ctrl #(
  parameter int MAX_ROW_PIXELS = psu_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_BYTES_PER_PIXEL = psu_pkg::DEF_MAX_BYTES_PER_PIXEL,
  localparam int ROW_DEPTH = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL,
  localparam int ADDR_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1,
  localparam int BSEL_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic [2:0]          bytes_per_pixel,
  input  logic [12:0]         row_pixels,
  input  logic [15:0]         image_rows,
  output psu_pkg::psu_item_t  item,
  output logic [ADDR_W-1:0]   col_addr,
  output logic [BSEL_W-1:0]   bsel
);
  import psu_pkg::*;

  localparam int COL_W = $clog2(ROW_DEPTH + 1);
  localparam int PIX_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int BPP_W = $clog2(MAX_BYTES_PER_PIXEL + 1);

  logic             expect_filter;
  logic [2:0]       row_filter;
  logic [COL_W-1:0] byte_column;
  logic [15:0]      row_counter;

  logic [31:0]            bpp32;
  logic [31:0]            pix32;
  logic [BPP_W-1:0]       eff_bpp;
  logic [PIX_W-1:0]       eff_pix;
  logic [PIX_W+BPP_W-1:0] row_len;
  logic [COL_W:0]         col_inc;
  logic [16:0]            row_inc;
  logic [16:0]            rows;
  logic                   last_byte;
  logic                   last_row;

  always_comb begin
    bpp32 = {29'd0, bytes_per_pixel};
    if (bpp32 == 32'd0) begin
      bpp32 = 32'd1;
    end else if (bpp32 > 32'(MAX_BYTES_PER_PIXEL)) begin
      bpp32 = 32'(MAX_BYTES_PER_PIXEL);
    end
    pix32 = {19'd0, row_pixels};
    if (pix32 == 32'd0) begin
      pix32 = 32'd1;
    end else if (pix32 > 32'(MAX_ROW_PIXELS)) begin
      pix32 = 32'(MAX_ROW_PIXELS);
    end
  end

  assign eff_bpp = bpp32[BPP_W-1:0];
  assign eff_pix = pix32[PIX_W-1:0];
  assign row_len = {{BPP_W{1'b0}}, eff_pix} * {{PIX_W{1'b0}}, eff_bpp};
  assign bsel = BSEL_W'(eff_bpp - BPP_W'(1));

  assign col_inc = {1'b0, byte_column} + (COL_W+1)'(1);
  assign row_inc = {1'b0, row_counter} + 17'd1;
  assign rows = (image_rows == 16'd0) ? 17'd1 : {1'b0, image_rows};
  assign last_byte = 32'(col_inc) >= 32'(row_len);
  assign last_row = row_inc >= rows;

  assign col_addr = byte_column[ADDR_W-1:0];

  always_comb begin
    item.is_data = ~expect_filter;
    item.filter = row_filter;
    item.have_left = 32'(byte_column) >= 32'(eff_bpp);
    item.have_above = row_counter != 16'd0;
    item.in_range = 32'(byte_column) < 32'(ROW_DEPTH);
    item.row_end = last_byte;
    item.image_end = last_byte & last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_filter <= 1'b1;
      row_filter <= FILT_NONE;
      byte_column <= '0;
      row_counter <= '0;
    end else if (accept) begin
      if (expect_filter) begin
        row_filter <= (in_byte > 8'(FILT_PAETH)) ? FILT_NONE : in_byte[2:0];
        expect_filter <= 1'b0;
        byte_column <= '0;
      end else if (last_byte) begin
        expect_filter <= 1'b1;
        byte_column <= '0;
        row_counter <= last_row ? 16'd0 : row_inc[15:0];
      end else begin
        byte_column <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

// File: hdl/psu_recon.sv
// Reconstruction stage: neighbor selection, filter prediction and output register.
`timescale 1ns / 1ps
module psu_recon #(
  parameter int MAX_ROW_PIXELS = psu_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_BYTES_PER_PIXEL = psu_pkg::DEF_MAX_BYTES_PER_PIXEL,
  localparam int ROW_DEPTH = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL,
  localparam int ADDR_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1,
  localparam int BSEL_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  psu_pkg::psu_item_t item,
  input  logic [7:0]         in_byte,
  input  logic [ADDR_W-1:0]  col_addr,
  input  logic [BSEL_W-1:0]  bsel,
  input  logic [7:0]         above_byte,
  output logic               take_ready,
  output logic               buf_we,
  output logic [ADDR_W-1:0]  buf_waddr,
  output logic [7:0]         buf_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel_byte,
  output logic               row_end,
  output logic               image_end
);
  import psu_pkg::*;

  logic              s1_valid;
  psu_item_t         s1_item;
  logic [7:0]        s1_x;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_adv;
  logic              s1_emit;

  logic [7:0] left_bytes [MAX_BYTES_PER_PIXEL];
  logic [7:0] upper_left_bytes [MAX_BYTES_PER_PIXEL];

  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        avg_sum;
  logic signed [9:0] sa;
  logic signed [9:0] sb;
  logic signed [9:0] sc;
  logic signed [9:0] dpa;
  logic signed [9:0] dpb;
  logic signed [9:0] dpc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [7:0]        pred;
  logic [7:0]        y;

  assign s1_adv = s1_valid & (~out_valid | out_ready);
  assign s1_emit = s1_adv & s1_item.is_data;
  assign take_ready = ~s1_valid | s1_adv;

  assign a = s1_item.have_left ? left_bytes[bsel] : 8'd0;
  assign b = (s1_item.have_above & s1_item.in_range) ? above_byte : 8'd0;
  assign c = (s1_item.have_left & s1_item.have_above) ? upper_left_bytes[bsel] : 8'd0;

  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign sa = {2'b00, a};
  assign sb = {2'b00, b};
  assign sc = {2'b00, c};
  assign dpa = sb - sc;
  assign dpb = sa - sc;
  assign dpc = sa + sb - sc - sc;
  assign pa = dpa[9] ? 10'(-dpa) : 10'(dpa);
  assign pb = dpb[9] ? 10'(-dpb) : 10'(dpb);
  assign pc = dpc[9] ? 10'(-dpc) : 10'(dpc);

  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
    case (s1_item.filter)
      FILT_SUB: pred = a;
      FILT_UP: pred = b;
      FILT_AVG: pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default: pred = 8'd0;
    endcase
  end

  assign y = s1_x + pred;

  assign buf_we = s1_emit & s1_item.in_range;
  assign buf_waddr = s1_addr;
  assign buf_wdata = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= accept | (s1_valid & ~s1_adv);
      out_valid <= s1_emit | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_x <= in_byte;
      s1_addr <= col_addr;
    end
    if (s1_emit) begin
      pixel_byte <= y;
      row_end <= s1_item.row_end;
      image_end <= s1_item.image_end;
      for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
        left_bytes[k] <= left_bytes[k-1];
        upper_left_bytes[k] <= upper_left_bytes[k-1];
      end
      left_bytes[0] <= y;
      upper_left_bytes[0] <= b;
    end
  end

endmodule

// File: hdl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter with its configuration registers.
// An accepted data byte passes the reconstruction stage register, then the output register,
// which holds while out_ready is low. Throughput: one stream byte per cycle while the output
// is not stalled, with the line buffer read at accept and written back from the reconstruction stage.
// Reset clears sequencing and handshake state; the line buffer is not cleared and
// holds undefined bytes until the first row has passed.
`timescale 1ns / 1ps
module png_scanline_unfilter #(
  parameter int MAX_ROW_PIXELS = psu_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_BYTES_PER_PIXEL = psu_pkg::DEF_MAX_BYTES_PER_PIXEL
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [psu_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      pixel_byte,
  output logic                            row_end,
  output logic                            image_end
);
  import psu_pkg::*;

  localparam int ROW_DEPTH = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL;
  localparam int ADDR_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int BSEL_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  logic [2:0]  bytes_per_pixel;
  logic [12:0] row_pixels;
  logic [15:0] image_rows;
  logic        cfg_write;

  logic              accept;
  psu_item_t         item;
  logic [ADDR_W-1:0] col_addr;
  logic [BSEL_W-1:0] bsel;
  logic [7:0]        above_byte;
  logic              buf_we;
  logic [ADDR_W-1:0] buf_waddr;
  logic [7:0]        buf_wdata;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= RST_BYTES_PER_PIXEL;
      row_pixels <= RST_ROW_PIXELS;
      image_rows <= RST_IMAGE_ROWS;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= pwdata[2:0];
        REG_ROW_PIXELS: row_pixels <= pwdata[12:0];
        REG_IMAGE_ROWS: image_rows <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BYTES_PER_PIXEL: prdata = {29'd0, bytes_per_pixel};
      REG_ROW_PIXELS: prdata = {19'd0, row_pixels};
      REG_IMAGE_ROWS: prdata = {16'd0, image_rows};
      default: prdata = '0;
    endcase
  end

  assign accept = in_valid & in_ready;

  psu_ctrl #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_byte(in_byte),
    .bytes_per_pixel(bytes_per_pixel),
    .row_pixels(row_pixels),
    .image_rows(image_rows),
    .item(item),
    .col_addr(col_addr),
    .bsel(bsel)
  );

  psu_ram #(
    .WIDTH(8),
    .DEPTH(ROW_DEPTH)
  ) u_line_buf (
    .clk(clk),
    .we(buf_we),
    .waddr(buf_waddr),
    .wdata(buf_wdata),
    .re(accept),
    .raddr(col_addr),
    .rdata(above_byte)
  );

  psu_recon #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
  ) u_recon (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .in_byte(in_byte),
    .col_addr(col_addr),
    .bsel(bsel),
    .above_byte(above_byte),
    .take_ready(in_ready),
    .buf_we(buf_we),
    .buf_waddr(buf_waddr),
    .buf_wdata(buf_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_byte(pixel_byte),
    .row_end(row_end),
    .image_end(image_end)
  );

endmodule
